### design/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int NUM_SEMAPHORES_DEF = 16;
   localparam int NUM_PROCESSES_DEF  = 32;

   localparam logic signed [15:0] CNT_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] CNT_MIN   = -16'sh8000;
   localparam logic        [15:0] LIMIT_ALL = 16'hFFFF;

   typedef enum logic [2:0] {
      OP_CREATE   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_RESET    = 3'd2,
      OP_SIGNAL   = 3'd3,
      OP_SIGNAL_N = 3'd4,
      OP_WAIT     = 3'd5,
      OP_TRY_WAIT = 3'd6,
      OP_QUERY    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_LIMIT   = 3'd2,
      ST_NORES   = 3'd3,
      ST_BLOCKED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      WAKE_NORMAL  = 2'd0,
      WAKE_DELETED = 2'd1,
      WAKE_RESET   = 2'd2
   } wake_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_SCAN,
      S_WALK,
      S_FLUSH
   } top_state_type;

   typedef enum logic [1:0] {
      WL_IDLE,
      WL_RUN,
      WL_DONE
   } wl_state_type;

   typedef struct packed {
      logic [7:0] sem;
      logic [7:0] prio;
      logic [4:0] proc;
   } wl_entry_type;

   typedef struct packed {
      logic         go;
      logic         insert;
      wl_entry_type entry;
      logic [15:0]  limit;
   } wl_cmd_type;

   typedef struct packed {
      logic       wake;
      logic [4:0] proc;
      logic       done;
      logic       full;
   } wl_evt_type;

   typedef struct packed {
      status_type    status;
      logic [15:0]   value;
      logic          woken;
      logic [4:0]    proc;
      wake_code_type code;
   } rsp_payload_type;

endpackage
`default_nettype wire

### design/cst_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ifs
// Request and response channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface cst_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic [7:0]         sem_id;
   logic signed [15:0] count_value;
   logic [4:0]         proc_id;
   logic [7:0]         proc_priority;

   modport source (output valid, operation, sem_id, count_value, proc_id, proc_priority,
                   input ready);
   modport sink (input valid, operation, sem_id, count_value, proc_id, proc_priority,
                 output ready);
endinterface

interface cst_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [15:0] value;
   logic               woken_valid;
   logic [4:0]         woken_proc;
   logic [1:0]         wake_code;
   logic               last;

   modport source (output valid, status, value, woken_valid, woken_proc, wake_code, last,
                   input ready);
   modport sink (input valid, status, value, woken_valid, woken_proc, wake_code, last,
                 output ready);
endinterface
`default_nettype wire

### design/cst_count_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_count_ram
// Semaphore count store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cst_count_ram #(
   parameter int DEPTH = cst_pkg::NUM_SEMAPHORES_DEF,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [15:0]   wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [15:0]   rdata
);

   logic [15:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

### design/cst_wait_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_wait_list
// Priority-ordered wait list in a memory. One walk per command, one entry
// per cycle unless hold stalls a wake: insert in priority order, or remove matching waiters in order.
// ----------------------------------------------------------------------------
module cst_wait_list #(
   parameter int NUM_PROCESSES = cst_pkg::NUM_PROCESSES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cst_pkg::wl_cmd_type cmd,
   input  wire logic                hold,
   output cst_pkg::wl_evt_type      evt
);

   localparam int PIW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int LW  = $clog2(NUM_PROCESSES + 1);

   cst_pkg::wl_entry_type mem [NUM_PROCESSES];
   cst_pkg::wl_entry_type rd_q;
   logic [PIW-1:0]        rd_addr;
   logic                  we;
   logic [PIW-1:0]        waddr;
   cst_pkg::wl_entry_type wdata;

   cst_pkg::wl_state_type wst_ff, wst_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [LW-1:0]         r_ff, r_in;
   logic [LW-1:0]         w_ff, w_in;
   logic [LW-1:0]         removed_ff, removed_in;
   cst_pkg::wl_entry_type carry_ff, carry_in;
   logic                  ins_ff, ins_in;
   logic                  insert_ff, insert_in;
   logic [15:0]           limit_ff, limit_in;
   logic [7:0]            key_ff, key_in;
   logic [7:0]            prio_ff, prio_in;
   logic [LW-1:0]         r_nxt;
   logic                  match;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wst_ff <= cst_pkg::WL_IDLE;
         len_ff <= '0;
      end else begin
         wst_ff <= wst_in;
         len_ff <= len_in;
      end
      r_ff       <= r_in;
      w_ff       <= w_in;
      removed_ff <= removed_in;
      carry_ff   <= carry_in;
      ins_ff     <= ins_in;
      insert_ff  <= insert_in;
      limit_ff   <= limit_in;
      key_ff     <= key_in;
      prio_ff    <= prio_in;
   end

   always_comb begin
      wst_in     = wst_ff;
      len_in     = len_ff;
      r_in       = r_ff;
      w_in       = w_ff;
      removed_in = removed_ff;
      carry_in   = carry_ff;
      ins_in     = ins_ff;
      insert_in  = insert_ff;
      limit_in   = limit_ff;
      key_in     = key_ff;
      prio_in    = prio_ff;
      r_nxt      = r_ff + 1'b1;
      rd_addr    = r_ff[PIW-1:0];
      we         = 1'b0;
      waddr      = r_ff[PIW-1:0];
      wdata      = carry_ff;
      match      = (rd_q.sem == key_ff) && (16'(removed_ff) < limit_ff);
      evt        = '0;
      evt.full   = (len_ff == LW'(NUM_PROCESSES));
      unique case (wst_ff)
         cst_pkg::WL_IDLE: begin
            rd_addr = '0;
            if (cmd.go) begin
               r_in       = '0;
               w_in       = '0;
               removed_in = '0;
               carry_in   = cmd.entry;
               ins_in     = 1'b0;
               insert_in  = cmd.insert;
               limit_in   = cmd.limit;
               key_in     = cmd.entry.sem;
               prio_in    = cmd.entry.prio;
               wst_in     = cst_pkg::WL_RUN;
            end
         end
         cst_pkg::WL_RUN: begin
            if (r_ff == len_ff) begin
               if (insert_ff) begin
                  // append whatever is still carried at the tail
                  we     = 1'b1;
                  waddr  = len_ff[PIW-1:0];
                  wdata  = carry_ff;
                  len_in = len_ff + 1'b1;
               end else begin
                  len_in = w_ff;
               end
               wst_in = cst_pkg::WL_DONE;
            end else if (insert_ff) begin
               if (ins_ff || (rd_q.prio < prio_ff)) begin
                  // drop the carried entry here and carry this one up
                  we       = 1'b1;
                  waddr    = r_ff[PIW-1:0];
                  wdata    = carry_ff;
                  carry_in = rd_q;
                  ins_in   = 1'b1;
               end
               r_in    = r_nxt;
               rd_addr = r_nxt[PIW-1:0];
            end else if (match) begin
               if (!hold) begin
                  evt.wake   = 1'b1;
                  evt.proc   = rd_q.proc;
                  removed_in = removed_ff + 1'b1;
                  r_in       = r_nxt;
                  rd_addr    = r_nxt[PIW-1:0];
               end
            end else begin
               // compact the kept entry down
               we      = 1'b1;
               waddr   = w_ff[PIW-1:0];
               wdata   = rd_q;
               w_in    = w_ff + 1'b1;
               r_in    = r_nxt;
               rd_addr = r_nxt[PIW-1:0];
            end
         end
         cst_pkg::WL_DONE: begin
            evt.done = 1'b1;
            wst_in   = cst_pkg::WL_IDLE;
         end
         default: wst_in = cst_pkg::WL_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### design/counting_semaphore_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Counting semaphore manager with a shared priority wait list.
// ----------------------------------------------------------------------------
// Each request is looked up in S_LOOK and closed in S_FLUSH with its last beat;
//   create scans the semaphore ids in S_SCAN in between (up to NUM_SEMAPHORES).
// Requests that touch the wait list walk it in S_WALK in between, one entry per
//   cycle unless a blocked output register holds a wake; each wake sends a beat.
// One request in flight at a time; the last beat waits in an output register
//   while the next request is accepted.
// Synchronous reset empties the semaphore table and the wait list at once.
module counting_semaphore_table #(
   parameter int NUM_SEMAPHORES = cst_pkg::NUM_SEMAPHORES_DEF,
   parameter int NUM_PROCESSES  = cst_pkg::NUM_PROCESSES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   cst_req_if.sink  req_bus,
   cst_rsp_if.source rsp_bus
);

   localparam int SIW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

   cst_pkg::top_state_type   state_ff, state_in;
   cst_pkg::op_type          op_ff;
   logic [7:0]               sid_ff;
   logic signed [15:0]       cv_ff;
   logic [4:0]               proc_ff;
   logic [7:0]               prio_ff;
   logic [SIW-1:0]           scan_ff, scan_in;
   logic [NUM_SEMAPHORES-1:0] in_use_ff, in_use_in;
   cst_pkg::wake_code_type   code_ff, code_in;
   cst_pkg::rsp_payload_type pend_ff, pend_in;
   cst_pkg::rsp_payload_type out_ff;
   logic                     out_valid_ff;
   logic                     out_last_ff;

   logic                     push;
   logic                     push_last;
   logic                     can_push;
   logic                     accept;

   logic                     cnt_we;
   logic [SIW-1:0]           cnt_waddr;
   logic [15:0]              cnt_wdata;
   logic signed [15:0]       cnt_q;

   cst_pkg::wl_cmd_type      wl_cmd;
   cst_pkg::wl_evt_type      wl_evt;
   logic                     wl_hold;

   logic [SIW-1:0]           use_idx;
   logic                     sid_ok;
   logic signed [16:0]       sum17;
   logic        [16:0]       negc17;
   logic        [16:0]       due17;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == cst_pkg::S_IDLE) && !reset;
   assign can_push      = !out_valid_ff || rsp_bus.ready;
   assign wl_hold       = !can_push;

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_ff.status;
   assign rsp_bus.value       = out_ff.value;
   assign rsp_bus.woken_valid = out_ff.woken;
   assign rsp_bus.woken_proc  = out_ff.proc;
   assign rsp_bus.wake_code   = out_ff.code;
   assign rsp_bus.last        = out_last_ff;

   cst_count_ram #(
      .DEPTH (NUM_SEMAPHORES),
      .AW    (SIW)
   ) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (req_bus.sem_id[SIW-1:0]),
      .rdata (cnt_q)
   );

   cst_wait_list #(
      .NUM_PROCESSES (NUM_PROCESSES)
   ) u_wait_list (
      .clock (clock),
      .reset (reset),
      .cmd   (wl_cmd),
      .hold  (wl_hold),
      .evt   (wl_evt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cst_pkg::S_IDLE;
         in_use_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_use_ff <= in_use_in;
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         op_ff   <= cst_pkg::op_type'(req_bus.operation);
         sid_ff  <= req_bus.sem_id;
         cv_ff   <= req_bus.count_value;
         proc_ff <= req_bus.proc_id;
         prio_ff <= req_bus.proc_priority;
      end
      if (push) begin
         out_ff      <= pend_ff;
         out_last_ff <= push_last;
      end
      scan_ff <= scan_in;
      code_ff <= code_in;
      pend_ff <= pend_in;
   end

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      code_in   = code_ff;
      pend_in   = pend_ff;
      in_use_in = in_use_ff;
      push      = 1'b0;
      push_last = 1'b0;
      cnt_we    = 1'b0;
      cnt_waddr = sid_ff[SIW-1:0];
      cnt_wdata = cv_ff;
      wl_cmd    = '0;
      wl_cmd.entry.sem  = sid_ff;
      wl_cmd.entry.prio = prio_ff;
      wl_cmd.entry.proc = proc_ff;
      wl_cmd.limit      = cst_pkg::LIMIT_ALL;
      use_idx   = (state_ff == cst_pkg::S_SCAN) ? scan_ff : sid_ff[SIW-1:0];
      sid_ok    = ({1'b0, sid_ff} < 9'(NUM_SEMAPHORES)) && in_use_ff[use_idx];
      sum17     = {cnt_q[15], cnt_q} + {cv_ff[15], cv_ff};
      negc17    = 17'(-{cnt_q[15], cnt_q});
      due17     = (negc17 < {1'b0, cv_ff}) ? negc17 : {1'b0, cv_ff};

      unique case (state_ff)
         cst_pkg::S_IDLE: begin
            if (accept) begin
               state_in = cst_pkg::S_LOOK;
            end
         end
         cst_pkg::S_LOOK: begin
            pend_in        = '0;
            pend_in.status = cst_pkg::ST_OK;
            code_in        = cst_pkg::WAKE_NORMAL;
            state_in       = cst_pkg::S_FLUSH;
            if (op_ff == cst_pkg::OP_CREATE) begin
               if (cv_ff < 0) begin
                  pend_in.status = cst_pkg::ST_INVALID;
               end else begin
                  scan_in  = '0;
                  state_in = cst_pkg::S_SCAN;
               end
            end else if (!sid_ok) begin
               pend_in.status = cst_pkg::ST_INVALID;
            end else begin
               unique case (op_ff)
                  cst_pkg::OP_DELETE: begin
                     in_use_in[sid_ff[SIW-1:0]] = 1'b0;
                     code_in   = cst_pkg::WAKE_DELETED;
                     wl_cmd.go = 1'b1;
                     state_in  = cst_pkg::S_WALK;
                  end
                  cst_pkg::OP_RESET: begin
                     if (cv_ff < 0) begin
                        pend_in.status = cst_pkg::ST_INVALID;
                     end else begin
                        cnt_we    = 1'b1;
                        code_in   = cst_pkg::WAKE_RESET;
                        wl_cmd.go = 1'b1;
                        state_in  = cst_pkg::S_WALK;
                     end
                  end
                  cst_pkg::OP_SIGNAL: begin
                     if (cnt_q == cst_pkg::CNT_MAX) begin
                        pend_in.status = cst_pkg::ST_LIMIT;
                     end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_q + 16'sd1;
                        if (cnt_q < 0) begin
                           wl_cmd.go    = 1'b1;
                           wl_cmd.limit = 16'd1;
                           state_in     = cst_pkg::S_WALK;
                        end
                     end
                  end
                  cst_pkg::OP_SIGNAL_N: begin
                     if (cv_ff >= 0) begin
                        if (!sum17[16] && sum17[15]) begin
                           pend_in.status = cst_pkg::ST_LIMIT;
                        end else begin
                           cnt_we    = 1'b1;
                           cnt_wdata = sum17[15:0];
                           if ((cnt_q < 0) && (due17 != '0)) begin
                              wl_cmd.go    = 1'b1;
                              wl_cmd.limit = due17[15:0];
                              state_in     = cst_pkg::S_WALK;
                           end
                        end
                     end
                  end
                  cst_pkg::OP_WAIT: begin
                     if (cnt_q == cst_pkg::CNT_MIN) begin
                        pend_in.status = cst_pkg::ST_LIMIT;
                     end else if (cnt_q <= 0) begin
                        if (wl_evt.full) begin
                           pend_in.status = cst_pkg::ST_NORES;
                        end else begin
                           cnt_we         = 1'b1;
                           cnt_wdata      = cnt_q - 16'sd1;
                           pend_in.status = cst_pkg::ST_BLOCKED;
                           wl_cmd.go      = 1'b1;
                           wl_cmd.insert  = 1'b1;
                           state_in       = cst_pkg::S_WALK;
                        end
                     end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_q - 16'sd1;
                     end
                  end
                  cst_pkg::OP_TRY_WAIT: begin
                     if (cnt_q == cst_pkg::CNT_MIN) begin
                        pend_in.status = cst_pkg::ST_LIMIT;
                     end else if (cnt_q > 0) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_q - 16'sd1;
                     end else begin
                        pend_in.status = cst_pkg::ST_NORES;
                     end
                  end
                  cst_pkg::OP_QUERY: begin
                     pend_in.value = cnt_q;
                  end
                  default: pend_in.status = cst_pkg::ST_INVALID;
               endcase
            end
         end
         cst_pkg::S_SCAN: begin
            if (!in_use_ff[scan_ff]) begin
               in_use_in[scan_ff] = 1'b1;
               cnt_we        = 1'b1;
               cnt_waddr     = scan_ff;
               pend_in.value = 16'(scan_ff);
               state_in      = cst_pkg::S_FLUSH;
            end else if (32'(scan_ff) == NUM_SEMAPHORES - 1) begin
               pend_in.status = cst_pkg::ST_NORES;
               state_in       = cst_pkg::S_FLUSH;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         cst_pkg::S_WALK: begin
            // each wake sends the held beat on and becomes the new held beat
            if (wl_evt.wake) begin
               push         = 1'b1;
               pend_in.value = '0;
               pend_in.woken = 1'b1;
               pend_in.proc  = wl_evt.proc;
               pend_in.code  = code_ff;
            end
            if (wl_evt.done) begin
               state_in = cst_pkg::S_FLUSH;
            end
         end
         cst_pkg::S_FLUSH: begin
            if (can_push) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = cst_pkg::S_IDLE;
            end
         end
         default: state_in = cst_pkg::S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_wake_not_stalled: assert property (@(posedge clock) disable iff (reset)
      wl_evt.wake |-> can_push)
      else $error("wake beat issued while output register blocked");

   a_look_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cst_pkg::S_LOOK) |-> $past(accept))
      else $error("lookup without an accepted request");

   a_flush_sends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cst_pkg::S_FLUSH && state_in == cst_pkg::S_IDLE)
         |=> (out_valid_ff && out_last_ff))
      else $error("request closed without a last beat");

   a_walk_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      wl_evt.wake |-> (state_ff == cst_pkg::S_WALK))
      else $error("wake outside a list walk");
`endif

endmodule
`default_nettype wire

### tb/cst_tb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_tb_ifs
// Request and result beat types used by the testbench.
// ----------------------------------------------------------------------------
package cst_tb_types;

   typedef struct packed {
      cst_pkg::op_type    op;
      logic [7:0]         sid;
      logic signed [15:0] cnt;
      logic [4:0]         proc;
      logic [7:0]         prio;
   } sem_req_type;

   typedef struct packed {
      cst_pkg::status_type    status;
      logic signed [15:0]     value;
      logic                   woken;
      logic [4:0]             proc;
      cst_pkg::wake_code_type code;
      logic                   last;
   } sem_rsp_type;
endpackage

### tb/tb_counting_semaphore_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_table
// Drives random and directed semaphore requests with random gaps and output
// stalls, predicts every result beat from a behavioral model of the table
// and priority wait list, and compares beats in order.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_table;

   localparam int NSEM  = 16;
   localparam int NPROC = 32;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();

   counting_semaphore_table u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   // model state
   logic               sem_used [NSEM];
   logic signed [15:0] sem_cnt [NSEM];
   logic [7:0]         wl_sem [$];
   logic [7:0]         wl_prio [$];
   logic [4:0]         wl_proc [$];

   cst_tb_types::sem_req_type pending_reqs [$];
   cst_tb_types::sem_rsp_type expected_beats [$];
   int       errors = 0;
   int       hold_drain = 0;
   logic     drive_done = 0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task automatic push_beat(input cst_pkg::status_type st, input logic signed [15:0] v,
                            input logic w, input logic [4:0] p,
                            input cst_pkg::wake_code_type c);
      cst_tb_types::sem_rsp_type b;
      b.status = st; b.value = v; b.woken = w; b.proc = p; b.code = c; b.last = 1'b1;
      if (expected_beats.size() > 0 && w)
         expected_beats[$].last = 1'b0;
      expected_beats.push_back(b);
   endtask

   // release up to lim waiters of s; appends the woken processes to woke
   function automatic void release_waiters(input int s, input int lim, ref logic [4:0] woke[$]);
      int n;
      for (n = 0; n < lim; n++) begin
         int i;
         int hit;
         hit = -1;
         for (i = 0; i < wl_sem.size(); i++)
            if (hit < 0 && int'(wl_sem[i]) == s) hit = i;
         if (hit < 0) break;
         woke.push_back(wl_proc[hit]);
         wl_sem.delete(hit); wl_prio.delete(hit); wl_proc.delete(hit);
      end
   endfunction

   task automatic predict_semaphore(input cst_tb_types::sem_req_type r);
      cst_pkg::status_type    st;
      logic signed [15:0]     v;
      logic [4:0]             woke [$];
      cst_pkg::wake_code_type code;
      logic                   ok;
      int                     c, n, s, pos;
      st = cst_pkg::ST_OK; v = 0; code = cst_pkg::WAKE_NORMAL;
      ok = r.sid < NSEM && sem_used[r.sid[3:0]];
      c = ok ? int'(sem_cnt[r.sid[3:0]]) : 0;
      n = int'(r.cnt);
      s = int'(r.sid);
      if (r.op == cst_pkg::OP_CREATE) begin
         if (n < 0) st = cst_pkg::ST_INVALID;
         else begin
            st = cst_pkg::ST_NORES;
            for (int i = 0; i < NSEM; i++)
               if (st == cst_pkg::ST_NORES && !sem_used[i]) begin
                  sem_used[i] = 1; sem_cnt[i] = r.cnt; st = cst_pkg::ST_OK; v = 16'(i);
               end
         end
      end else if (!ok) st = cst_pkg::ST_INVALID;
      else case (r.op)
         cst_pkg::OP_DELETE: begin
            code = cst_pkg::WAKE_DELETED; release_waiters(s, NPROC, woke); sem_used[s] = 0;
         end
         cst_pkg::OP_RESET: begin
            if (n < 0) st = cst_pkg::ST_INVALID;
            else begin
               code = cst_pkg::WAKE_RESET; sem_cnt[s] = r.cnt;
               release_waiters(s, NPROC, woke);
            end
         end
         cst_pkg::OP_SIGNAL: begin
            if (c == 32767) st = cst_pkg::ST_LIMIT;
            else begin
               sem_cnt[s] = 16'(c + 1);
               if (c + 1 <= 0) release_waiters(s, 1, woke);
            end
         end
         cst_pkg::OP_SIGNAL_N: begin
            if (n >= 0) begin
               if (32767 - c < n) st = cst_pkg::ST_LIMIT;
               else begin
                  sem_cnt[s] = 16'(c + n);
                  if (c < 0) release_waiters(s, (-c < n) ? -c : n, woke);
               end
            end
         end
         cst_pkg::OP_WAIT: begin
            if (c == -32768) st = cst_pkg::ST_LIMIT;
            else if (c <= 0) begin
               if (wl_sem.size() >= NPROC) st = cst_pkg::ST_NORES;
               else begin
                  sem_cnt[s] = 16'(c - 1);
                  pos = 0;
                  while (pos < wl_prio.size() && wl_prio[pos] >= r.prio) pos++;
                  wl_sem.insert(pos, r.sid); wl_prio.insert(pos, r.prio);
                  wl_proc.insert(pos, r.proc);
                  st = cst_pkg::ST_BLOCKED;
               end
            end else sem_cnt[s] = 16'(c - 1);
         end
         cst_pkg::OP_TRY_WAIT: begin
            if (c == -32768) st = cst_pkg::ST_LIMIT;
            else if (c > 0) sem_cnt[s] = 16'(c - 1);
            else st = cst_pkg::ST_NORES;
         end
         default: v = sem_cnt[s];
      endcase
      push_beat(st, v, 1'b0, 5'd0, cst_pkg::WAKE_NORMAL);
      foreach (woke[i]) push_beat(st, 16'sd0, 1'b1, woke[i], code);
   endtask

   // driver
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 0;
      end else if (req_bus.valid && !req_bus.ready) begin
      end else begin
         if (req_bus.valid) predict_semaphore(cst_tb_types::sem_req_type'({
            cst_pkg::op_type'(req_bus.operation), req_bus.sem_id, req_bus.count_value,
            req_bus.proc_id, req_bus.proc_priority}));
         if (hold_drain > 0 && pending_reqs.size() == hold_drain
             && (expected_beats.size() > 0 || req_bus.valid)) begin
            req_bus.valid <= 0;
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_bus.valid <= 0;
         end else if (pending_reqs.size() > 0) begin
            cst_tb_types::sem_req_type r;
            r = pending_reqs.pop_front();
            req_bus.valid <= 1;
            req_bus.operation <= r.op;
            req_bus.sem_id <= r.sid;
            req_bus.count_value <= r.cnt;
            req_bus.proc_id <= r.proc;
            req_bus.proc_priority <= r.prio;
            gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) : 0;
         end else begin
            req_bus.valid <= 0;
            drive_done <= 1;
         end
      end
   end

   // monitor
   int stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            cst_tb_types::sem_rsp_type e;
            if (expected_beats.size() == 0) report("unexpected result beat");
            else begin
               e = expected_beats.pop_front();
               if (rsp_bus.status !== e.status)
                  report($sformatf("status %0d exp %0d", rsp_bus.status, e.status));
               if (rsp_bus.value !== e.value)
                  report($sformatf("value %0d exp %0d", rsp_bus.value, e.value));
               if (rsp_bus.woken_valid !== e.woken)
                  report($sformatf("woken_valid %0b exp %0b", rsp_bus.woken_valid, e.woken));
               if (rsp_bus.woken_proc !== e.proc)
                  report($sformatf("woken_proc %0d exp %0d", rsp_bus.woken_proc, e.proc));
               if (rsp_bus.wake_code !== e.code)
                  report($sformatf("wake_code %0d exp %0d", rsp_bus.wake_code, e.code));
               if (rsp_bus.last !== e.last)
                  report($sformatf("last %0b exp %0b", rsp_bus.last, e.last));
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= 1;
            if (rsp_bus.valid && rsp_bus.ready && $urandom_range(0, 3) == 0)
               stall <= int'($urandom_range(0, 15));
         end
      end
   end

   function automatic cst_tb_types::sem_req_type mk(input cst_pkg::op_type op, input int sid,
                                                     input int cnt, input int proc = 0,
                                                     input int prio = 0);
      cst_tb_types::sem_req_type r;
      r.op = op; r.sid = 8'(sid); r.cnt = 16'(cnt); r.proc = 5'(proc); r.prio = 8'(prio);
      return r;
   endfunction

   initial begin
      int k, sel, live;
      req_bus.valid = 0; req_bus.operation = 0; req_bus.sem_id = 0;
      req_bus.count_value = 0; req_bus.proc_id = 0; req_bus.proc_priority = 0;
      rsp_bus.ready = 0;
      foreach (sem_used[i]) begin sem_used[i] = 0; sem_cnt[i] = 0; end
      // directed: each special case
      pending_reqs.push_back(mk(cst_pkg::OP_CREATE, 0, -1));
      pending_reqs.push_back(mk(cst_pkg::OP_CREATE, 255, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_CREATE, 0, 32767));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL, 1, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL, 255, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL_N, 0, 5));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL_N, 1, -32768));
      pending_reqs.push_back(mk(cst_pkg::OP_WAIT, 0, 0, 31, 255));
      pending_reqs.push_back(mk(cst_pkg::OP_WAIT, 0, 0, 3, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_WAIT, 0, 0, 3, 255));
      pending_reqs.push_back(mk(cst_pkg::OP_TRY_WAIT, 0, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_QUERY, 0, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL_N, 0, 2));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL, 0, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_RESET, 0, -5));
      pending_reqs.push_back(mk(cst_pkg::OP_RESET, 0, 32767));
      pending_reqs.push_back(mk(cst_pkg::OP_WAIT, 0, 0, 1, 1));
      pending_reqs.push_back(mk(cst_pkg::OP_DELETE, 0, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_QUERY, 0, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_DELETE, 200, 0));
      // random: mostly valid ids, small counts, occasional extremes
      for (k = 0; k < 390; k++) begin
         cst_tb_types::sem_req_type r;
         sel = int'($urandom_range(0, 99));
         r.op = cst_pkg::op_type'($urandom_range(0, 7));
         if (sel < 12) r.op = cst_pkg::OP_WAIT;
         else if (sel < 20) r.op = cst_pkg::OP_SIGNAL;
         r.sid = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 5));
         case ($urandom_range(0, 9))
            0: r.cnt = 16'sh7FFF;
            1: r.cnt = 16'($urandom_range(0, 65535));
            2: r.cnt = 16'(-int'($urandom_range(1, 3)));
            default: r.cnt = 16'($urandom_range(0, 4));
         endcase
         if (r.op == cst_pkg::OP_RESET && $urandom_range(0, 1)) r.cnt = -16'sd32768;
         r.proc = 5'($urandom_range(0, 31));
         r.prio = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
         pending_reqs.push_back(r);
      end
      // push the wait list toward full and a count toward the positive limit
      pending_reqs.push_back(mk(cst_pkg::OP_CREATE, 0, 0));
      for (k = 0; k < 34; k++)
         pending_reqs.push_back(mk(cst_pkg::OP_WAIT, 7 - k % 8, 0, k,
                                   int'($urandom_range(0, 255))));
      for (k = 0; k < 8; k++) pending_reqs.push_back(mk(cst_pkg::OP_DELETE, k, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_CREATE, 0, 0));
      for (k = 0; k < 16; k++) pending_reqs.push_back(mk(cst_pkg::OP_CREATE, 0, 1));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL_N, 0, 32767));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL, 0, 0));
      pending_reqs.push_back(mk(cst_pkg::OP_SIGNAL_N, 0, 1));
      pending_reqs.push_back(mk(cst_pkg::OP_QUERY, 0, 0));
      live = pending_reqs.size();
      hold_drain = live / 2;
      repeat (6) @(posedge clock);
      reset <= 0;
      wait (drive_done && expected_beats.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
